FILE: rtl/core/spc_pkg.sv
package spc_pkg;

	// luma and chroma coefficients in 16 fraction bits
	localparam logic [14:0] Y_R_Q16 = 15'd19595;
	localparam logic [15:0] Y_G_Q16 = 16'd38470;
	localparam logic [12:0] Y_B_Q16 = 13'd7471;
	localparam logic [15:0] CR_Q16  = 16'd46727;
	localparam logic [15:0] CB_Q16  = 16'd36962;

	// ratio limit scale (thousandths)
	localparam logic [9:0] MILLI = 10'd1000;

	// mask codes
	localparam logic [7:0] MASK_SKIN  = 8'h00;
	localparam logic [7:0] MASK_OTHER = 8'hFF;

	// register map, word index
	typedef enum logic [2:0] {
		REG_HUE_LOW_MAX    = 3'd0,
		REG_HUE_HIGH_MIN   = 3'd1,
		REG_CB_MIN         = 3'd2,
		REG_CB_MAX         = 3'd3,
		REG_CR_MIN         = 3'd4,
		REG_CR_MAX         = 3'd5,
		REG_CHROMA_OFFSET  = 3'd6,
		REG_RG_LIMIT_MILLI = 3'd7
	} reg_idx_t;

	// register reset values
	localparam logic [8:0]  RST_HUE_LOW_MAX    = 9'd50;
	localparam logic [8:0]  RST_HUE_HIGH_MIN   = 9'd335;
	localparam logic [7:0]  RST_CB_MIN         = 8'd77;
	localparam logic [7:0]  RST_CB_MAX         = 8'd127;
	localparam logic [7:0]  RST_CR_MIN         = 8'd133;
	localparam logic [7:0]  RST_CR_MAX         = 8'd173;
	localparam logic [7:0]  RST_CHROMA_OFFSET  = 8'd0;
	localparam logic [11:0] RST_RG_LIMIT_MILLI = 12'd1185;

	// which channel holds the maximum
	typedef enum logic [1:0] {
		SEC_FLAT  = 2'd0,
		SEC_RED   = 2'd1,
		SEC_GREEN = 2'd2,
		SEC_BLUE  = 2'd3
	} sector_t;

endpackage

FILE: rtl/core/skin_pixel_classifier.sv
// skin pixel classifier
// input stream: one bgr pixel per transfer on s_tvalid / s_tready / s_tdata
// output stream: one mask per pixel on m_tvalid / m_tready / m_tdata, in input order
// mask_value is 0 for a skin pixel and 255 otherwise, skin_match is its 1-bit twin
// config: apb-style port, register i at byte address 4*i, pready always high;
// write registers only while no pixel is in flight
// latency: m_tvalid rises 3 cycles after the input transfer, the output transfer
//   follows at the earliest on the next edge, 4 edges after the input transfer
// throughput: one pixel per clock, each of the four pipeline stages takes a new pixel
//   every cycle; s1 max/min, luma and ratio products; s2 scaled hue, saturation,
//   chroma differences; s3 hue bound products and chroma multiplies; s4 chroma compares
// reset: asynchronous, clears all stage valid bits and loads the register defaults
// stall: when m_tready is low the pipeline compresses bubbles, then holds every stage;
//   s_tready drops only once all four stages are full, nothing is lost or repeated
module skin_pixel_classifier (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue [7:0], green [15:8], red [23:16]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // mask_value [7:0], skin_match [8], zero [15:9]
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ---------------------------------------------------------------
	// config registers
	// ---------------------------------------------------------------
	logic [8:0]  hue_low_max_q;
	logic [8:0]  hue_high_min_q;
	logic [7:0]  cb_min_q;
	logic [7:0]  cb_max_q;
	logic [7:0]  cr_min_q;
	logic [7:0]  cr_max_q;
	logic [7:0]  chroma_offset_q;
	logic [11:0] rg_limit_milli_q;

	logic                cfg_wr;
	spc_pkg::reg_idx_t   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = spc_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_max_q    <= spc_pkg::RST_HUE_LOW_MAX;
			hue_high_min_q   <= spc_pkg::RST_HUE_HIGH_MIN;
			cb_min_q         <= spc_pkg::RST_CB_MIN;
			cb_max_q         <= spc_pkg::RST_CB_MAX;
			cr_min_q         <= spc_pkg::RST_CR_MIN;
			cr_max_q         <= spc_pkg::RST_CR_MAX;
			chroma_offset_q  <= spc_pkg::RST_CHROMA_OFFSET;
			rg_limit_milli_q <= spc_pkg::RST_RG_LIMIT_MILLI;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				spc_pkg::REG_HUE_LOW_MAX:    hue_low_max_q    <= pwdata[8:0];
				spc_pkg::REG_HUE_HIGH_MIN:   hue_high_min_q   <= pwdata[8:0];
				spc_pkg::REG_CB_MIN:         cb_min_q         <= pwdata[7:0];
				spc_pkg::REG_CB_MAX:         cb_max_q         <= pwdata[7:0];
				spc_pkg::REG_CR_MIN:         cr_min_q         <= pwdata[7:0];
				spc_pkg::REG_CR_MAX:         cr_max_q         <= pwdata[7:0];
				spc_pkg::REG_CHROMA_OFFSET:  chroma_offset_q  <= pwdata[7:0];
				spc_pkg::REG_RG_LIMIT_MILLI: rg_limit_milli_q <= pwdata[11:0];
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			spc_pkg::REG_HUE_LOW_MAX:    prdata = {23'd0, hue_low_max_q};
			spc_pkg::REG_HUE_HIGH_MIN:   prdata = {23'd0, hue_high_min_q};
			spc_pkg::REG_CB_MIN:         prdata = {24'd0, cb_min_q};
			spc_pkg::REG_CB_MAX:         prdata = {24'd0, cb_max_q};
			spc_pkg::REG_CR_MIN:         prdata = {24'd0, cr_min_q};
			spc_pkg::REG_CR_MAX:         prdata = {24'd0, cr_max_q};
			spc_pkg::REG_CHROMA_OFFSET:  prdata = {24'd0, chroma_offset_q};
			spc_pkg::REG_RG_LIMIT_MILLI: prdata = {20'd0, rg_limit_milli_q};
		endcase
	end

	// ---------------------------------------------------------------
	// pipeline flow control
	// a stage loads when it is empty or its content moves on this cycle
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	assign en4 = !valid_s4 || m_tready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= s_tvalid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: max/min, sector, sum, ratio test, luma
	// ---------------------------------------------------------------
	logic [7:0]  in_b, in_g, in_r;
	logic [7:0]  mx, mn;
	logic [9:0]  sum_c;
	logic [17:0] r_milli;
	logic [19:0] lim_g;
	logic [23:0] y_c;
	spc_pkg::sector_t sector_c;

	assign in_b = s_tdata[7:0];
	assign in_g = s_tdata[15:8];
	assign in_r = s_tdata[23:16];

	always_comb begin
		mx = in_r;
		if (in_g > mx) mx = in_g;
		if (in_b > mx) mx = in_b;
		mn = in_r;
		if (in_g < mn) mn = in_g;
		if (in_b < mn) mn = in_b;
		// ties pick red, then green, then blue
		priority if (mx == mn)                         sector_c = spc_pkg::SEC_FLAT;
		else if (in_r >= in_g && in_r >= in_b)         sector_c = spc_pkg::SEC_RED;
		else if (in_g >= in_b)                         sector_c = spc_pkg::SEC_GREEN;
		else                                           sector_c = spc_pkg::SEC_BLUE;
	end

	assign sum_c   = 10'(in_r) + 10'(in_g) + 10'(in_b);
	assign r_milli = 18'(in_r) * 18'(spc_pkg::MILLI);
	assign lim_g   = 20'(rg_limit_milli_q) * 20'(in_g);
	// luma in 16 fraction bits, coefficients sum to one
	assign y_c     = 24'(in_r) * 24'(spc_pkg::Y_R_Q16)
	               + 24'(in_g) * 24'(spc_pkg::Y_G_Q16)
	               + 24'(in_b) * 24'(spc_pkg::Y_B_Q16);

	logic [7:0]  r_s1, g_s1, b_s1, d_s1;
	logic [9:0]  sum_s1;
	logic [23:0] y_s1;
	logic        ratio_ok_s1;
	spc_pkg::sector_t sector_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1        <= in_r;
			g_s1        <= in_g;
			b_s1        <= in_b;
			d_s1        <= mx - mn;
			sum_s1      <= sum_c;
			y_s1        <= y_c;
			sector_s1   <= sector_c;
			// green zero always fails
			ratio_ok_s1 <= (in_g != 8'd0) && (20'(r_milli) <= lim_g);
		end
	end

	// ---------------------------------------------------------------
	// stage 2: hue scaled by d, saturation, chroma differences
	// ---------------------------------------------------------------
	logic signed [18:0] rs, gs, bs, ds;
	logic signed [18:0] hn_raw;
	logic [11:0]        d5, sum3;
	logic signed [25:0] cr_diff_c, cb_diff_c;

	assign rs = signed'(19'(r_s1));
	assign gs = signed'(19'(g_s1));
	assign bs = signed'(19'(b_s1));
	assign ds = signed'(19'(d_s1));

	always_comb begin
		unique case (sector_s1)
			spc_pkg::SEC_FLAT:  hn_raw = 19'sd0;
			spc_pkg::SEC_RED: begin
				hn_raw = 19'sd60 * (gs - bs);
				// negative hue wraps by a full turn
				if (hn_raw < 19'sd0) hn_raw = hn_raw + 19'sd360 * ds;
			end
			spc_pkg::SEC_GREEN: hn_raw = 19'sd120 * ds + 19'sd60 * (bs - rs);
			spc_pkg::SEC_BLUE:  hn_raw = 19'sd240 * ds + 19'sd60 * (rs - gs);
		endcase
	end

	assign d5   = 12'(d_s1) * 12'd5;
	assign sum3 = 12'(sum_s1) * 12'd3;

	assign cr_diff_c = signed'({2'b00, r_s1, 16'd0}) - signed'({2'b00, y_s1});
	assign cb_diff_c = signed'({2'b00, b_s1, 16'd0}) - signed'({2'b00, y_s1});

	logic [16:0]        hn_s2;
	logic [7:0]         d_s2;
	logic               ratio_ok_s2, sat_ok_s2;
	logic signed [25:0] cr_diff_s2, cb_diff_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			hn_s2       <= hn_raw[16:0];
			d_s2        <= d_s1;
			ratio_ok_s2 <= ratio_ok_s1;
			// black pixel fails
			sat_ok_s2   <= (sum_s1 != 10'd0) && (d5 >= 12'(sum_s1)) && (d5 <= sum3);
			cr_diff_s2  <= cr_diff_c;
			cb_diff_s2  <= cb_diff_c;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: hue window test, chroma multiplies
	// ---------------------------------------------------------------
	logic [16:0]        hlm_d, hhm_d, d360;
	logic               hue_ok_c;
	logic signed [42:0] cr_prod_c, cb_prod_c;

	assign hlm_d    = 17'(hue_low_max_q) * 17'(d_s2);
	assign hhm_d    = 17'(hue_high_min_q) * 17'(d_s2);
	assign d360     = 17'(d_s2) * 17'd360;
	assign hue_ok_c = (hn_s2 <= hlm_d) || ((hn_s2 >= hhm_d) && (hn_s2 <= d360));

	// chroma with 32 fraction bits
	assign cr_prod_c = 43'(cr_diff_s2) * signed'({27'd0, spc_pkg::CR_Q16});
	assign cb_prod_c = 43'(cb_diff_s2) * signed'({27'd0, spc_pkg::CB_Q16});

	logic               hue_ok_s3, ratio_ok_s3, sat_ok_s3;
	logic signed [42:0] cr_prod_s3, cb_prod_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			hue_ok_s3   <= hue_ok_c;
			ratio_ok_s3 <= ratio_ok_s2;
			sat_ok_s3   <= sat_ok_s2;
			cr_prod_s3  <= cr_prod_c;
			cb_prod_s3  <= cb_prod_c;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: chroma windows (exclusive bounds), final mask
	// ---------------------------------------------------------------
	logic signed [42:0] off_q32, cr_v, cb_v;
	logic signed [42:0] cr_lo, cr_hi, cb_lo, cb_hi;
	logic               cr_ok, cb_ok, skin_c;

	assign off_q32 = signed'({3'b000, chroma_offset_q, 32'd0});
	assign cr_lo   = signed'({3'b000, cr_min_q, 32'd0});
	assign cr_hi   = signed'({3'b000, cr_max_q, 32'd0});
	assign cb_lo   = signed'({3'b000, cb_min_q, 32'd0});
	assign cb_hi   = signed'({3'b000, cb_max_q, 32'd0});

	assign cr_v  = cr_prod_s3 + off_q32;
	assign cb_v  = cb_prod_s3 + off_q32;
	assign cr_ok = (cr_v > cr_lo) && (cr_v < cr_hi);
	assign cb_ok = (cb_v > cb_lo) && (cb_v < cb_hi);

	assign skin_c = ratio_ok_s3 && hue_ok_s3 && sat_ok_s3 && cr_ok && cb_ok;

	logic [7:0] mask_s4;
	logic       skin_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			mask_s4 <= skin_c ? spc_pkg::MASK_SKIN : spc_pkg::MASK_OTHER;
			skin_s4 <= skin_c;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {7'd0, skin_s4, mask_s4};

endmodule

FILE: rtl/core/spc_checker.sv
module spc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// mask byte and match flag agree, padding is zero
	a_out_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:9] == 7'd0) &&
			((m_tdata[8] && m_tdata[7:0] == spc_pkg::MASK_SKIN) ||
			 (!m_tdata[8] && m_tdata[7:0] == spc_pkg::MASK_OTHER)))
		else $error("mask and match flag disagree");

	// the pipeline never blocks input while the output side moves
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input blocked while output drains");

	// input stays ready in the next cycle when no result is pending and no input is offered, now or at the last sample
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && !s_tvalid && s_tready && $past(!s_tvalid) && $past(!m_tvalid))
		|=> s_tready)
		else $error("ready lost without traffic");

endmodule

bind skin_pixel_classifier spc_checker u_spc_checker (.*);
